FILE: hdl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

`endif

FILE: hdl/bcdfp_pkg.sv
// types, constants and digit functions for the bcd fixed-point add/subtract
`timescale 1ns / 1ps
`default_nettype none

package bcdfp_pkg;

   localparam int DATA_W           = 64;
   localparam int NIBBLES          = DATA_W / 4;
   localparam int DIGITS_PER_STAGE = 4;
   localparam int STAGES           = NIBBLES / DIGITS_PER_STAGE;
   // input register, digit stages, output register
   localparam int PIPE_LATENCY     = STAGES + 2;

   localparam int INT_DIGITS_DEFAULT  = 8;
   localparam int FRAC_DIGITS_DEFAULT = 8;

   localparam logic ACTION_ADD = 1'b0;
   localparam logic ACTION_SUB = 1'b1;

   typedef struct packed {
      logic              action;
      logic [DATA_W-1:0] operand_a;
      logic [DATA_W-1:0] operand_b;
   } req_type;

   typedef struct packed {
      logic [DATA_W-1:0] result_bcd;
      logic              carry_digit;
      logic              negative;
      logic              bad_digit;
   } rsp_type;

   // everything one item carries down the digit pipeline
   typedef struct packed {
      logic              action;
      logic              bad;
      logic              carry;
      logic              borrow_ab;
      logic              borrow_ba;
      logic [DATA_W-1:0] a;
      logic [DATA_W-1:0] b;
      logic [DATA_W-1:0] sum;
      logic [DATA_W-1:0] diff_ab;
      logic [DATA_W-1:0] diff_ba;
   } pipe_type;

   // returns {carry, digit}
   function automatic logic [4:0] digit_add(input logic [3:0] x, input logic [3:0] y,
                                            input logic cin);
      logic [4:0] s;
      s = {1'b0, x} + {1'b0, y} + {4'b0000, cin};
      if (s >= 5'd10) begin
         digit_add = {1'b1, 4'(s - 5'd10)};
      end else begin
         digit_add = {1'b0, s[3:0]};
      end
   endfunction

   // returns {borrow, digit}
   function automatic logic [4:0] digit_sub(input logic [3:0] x, input logic [3:0] y,
                                            input logic bin);
      logic [4:0] t;
      t = {1'b0, x} - {1'b0, y} - {4'b0000, bin};
      if (t[4]) begin
         digit_sub = {1'b1, 4'(t + 5'd10)};
      end else begin
         digit_sub = {1'b0, t[3:0]};
      end
   endfunction

endpackage

`default_nettype wire

FILE: hdl/bcdfp_stage.sv
// one pipeline stage: ripple add and both subtractions over a slice of digits
`timescale 1ns / 1ps
`default_nettype none

module bcdfp_stage #(
   parameter int FIRST  = 0,
   parameter int DIGITS = bcdfp_pkg::NIBBLES
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   input  wire bcdfp_pkg::pipe_type in_pipe,
   output logic                    out_valid,
   output bcdfp_pkg::pipe_type     out_pipe
);

   logic                valid_ff;
   bcdfp_pkg::pipe_type pipe_ff;
   bcdfp_pkg::pipe_type pipe_in;

   always_comb begin
      logic [4:0] r_add;
      logic [4:0] r_ab;
      logic [4:0] r_ba;
      int         idx;
      pipe_in = in_pipe;
      for (int k = 0; k < bcdfp_pkg::DIGITS_PER_STAGE; k++) begin
         idx = FIRST + k;
         // slots above the top digit pass the chain through and stay zero
         if (idx < DIGITS) begin
            r_add = bcdfp_pkg::digit_add(in_pipe.a[4*idx +: 4], in_pipe.b[4*idx +: 4],
                                         pipe_in.carry);
            r_ab  = bcdfp_pkg::digit_sub(in_pipe.a[4*idx +: 4], in_pipe.b[4*idx +: 4],
                                         pipe_in.borrow_ab);
            r_ba  = bcdfp_pkg::digit_sub(in_pipe.b[4*idx +: 4], in_pipe.a[4*idx +: 4],
                                         pipe_in.borrow_ba);
            pipe_in.carry               = r_add[4];
            pipe_in.borrow_ab           = r_ab[4];
            pipe_in.borrow_ba           = r_ba[4];
            pipe_in.sum[4*idx +: 4]     = r_add[3:0];
            pipe_in.diff_ab[4*idx +: 4] = r_ab[3:0];
            pipe_in.diff_ba[4*idx +: 4] = r_ba[3:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      pipe_ff <= pipe_in;
   end

   assign out_valid = valid_ff;
   assign out_pipe  = pipe_ff;

endmodule

`default_nettype wire

FILE: hdl/bcd_fixed_point_add_subtract.sv
// top level: pipelined packed-bcd fixed-point adder / subtractor
// a result strobes out once its start beat has passed the input register, the digit stages and the output register
// throughput: one beat per cycle, busy is never raised; set by the digit pipeline,
//   four digit slots rippled in each of four stages between input and output registers
// reset: synchronous, active high, clears only the valid bits; no clearing pass
// results cannot be held off by the receiver, so nothing ever stalls
`timescale 1ns / 1ps
`default_nettype none

module bcd_fixed_point_add_subtract #(
   parameter int INT_DIGITS  = bcdfp_pkg::INT_DIGITS_DEFAULT,
   parameter int FRAC_DIGITS = bcdfp_pkg::FRAC_DIGITS_DEFAULT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire bcdfp_pkg::req_type req_item,
   output logic                   rsp_strobe,
   output bcdfp_pkg::rsp_type     rsp_item
);

   // digits handled, capped at the nibbles a field can hold
   localparam int DIGIT_COUNT = (INT_DIGITS + FRAC_DIGITS > bcdfp_pkg::NIBBLES)
                                ? bcdfp_pkg::NIBBLES : INT_DIGITS + FRAC_DIGITS;
   localparam logic [bcdfp_pkg::DATA_W-1:0] DIGIT_MASK =
      (DIGIT_COUNT >= bcdfp_pkg::NIBBLES) ? '1
      : ((bcdfp_pkg::DATA_W)'(1) << (4 * DIGIT_COUNT)) - (bcdfp_pkg::DATA_W)'(1);

   // every beat is taken; the pipeline never stalls
   assign busy = 1'b0;

   // input register: mask off nibbles above the top digit, flag bad digits
   logic                valid_ff;
   bcdfp_pkg::pipe_type pipe_ff;
   bcdfp_pkg::pipe_type pipe_in;

   always_comb begin
      logic bad;
      bad = 1'b0;
      pipe_in           = '0;
      pipe_in.action    = req_item.action;
      pipe_in.a         = req_item.operand_a & DIGIT_MASK;
      pipe_in.b         = req_item.operand_b & DIGIT_MASK;
      // masked nibbles read as zero, so all of them can be checked
      for (int i = 0; i < bcdfp_pkg::NIBBLES; i++) begin
         if (pipe_in.a[4*i +: 4] > 4'd9 || pipe_in.b[4*i +: 4] > 4'd9) begin
            bad = 1'b1;
         end
      end
      pipe_in.bad = bad;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= start & ~busy;
      end
   end

   always_ff @(posedge clock) begin
      pipe_ff <= pipe_in;
   end

   // digit pipeline: sum, a-b and b-a ripple side by side, carries registered
   logic                valid_st [0:bcdfp_pkg::STAGES];
   bcdfp_pkg::pipe_type pipe_st  [0:bcdfp_pkg::STAGES];

   assign valid_st[0] = valid_ff;
   assign pipe_st[0]  = pipe_ff;

   for (genvar s = 0; s < bcdfp_pkg::STAGES; s++) begin : g_stage
      bcdfp_stage #(
         .FIRST  (s * bcdfp_pkg::DIGITS_PER_STAGE),
         .DIGITS (DIGIT_COUNT)
      ) u_stage (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (valid_st[s]),
         .in_pipe   (pipe_st[s]),
         .out_valid (valid_st[s+1]),
         .out_pipe  (pipe_st[s+1])
      );
   end

   // output register: a borrow out of a-b means b was larger, so b-a is the magnitude
   bcdfp_pkg::pipe_type last;
   logic                strobe_ff;
   bcdfp_pkg::rsp_type  rsp_ff;
   bcdfp_pkg::rsp_type  rsp_in;

   assign last = pipe_st[bcdfp_pkg::STAGES];

   always_comb begin
      rsp_in = '0;
      if (!last.bad) begin
         unique case (last.action)
            bcdfp_pkg::ACTION_ADD: begin
               rsp_in.result_bcd  = last.sum;
               rsp_in.carry_digit = last.carry;
            end
            bcdfp_pkg::ACTION_SUB: begin
               rsp_in.result_bcd = last.borrow_ab ? last.diff_ba : last.diff_ab;
               rsp_in.negative   = last.borrow_ab;
            end
            default: begin
               rsp_in.result_bcd = '0;
            end
         endcase
      end
      rsp_in.bad_digit = last.bad;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= valid_st[bcdfp_pkg::STAGES];
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_item   = rsp_ff;

endmodule

`default_nettype wire

FILE: hdl/bcdfp_checker.sv
// port-level checker for the bcd fixed-point add/subtract, with its bind
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module bcdfp_checker (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               start,
   input wire logic               busy,
   input wire bcdfp_pkg::req_type req_item,
   input wire logic               rsp_strobe,
   input wire bcdfp_pkg::rsp_type rsp_item
);

   `ASSERT_ALWAYS(a_never_busy, clock, reset, !busy, "busy raised")
   `ASSERT_IMPLY(a_strobe_has_beat, clock, reset, rsp_strobe, $past(start && !busy, bcdfp_pkg::PIPE_LATENCY), "result without a start beat")
   `ASSERT_IMPLY(a_bad_clears, clock, reset, rsp_strobe && rsp_item.bad_digit, rsp_item.result_bcd == '0 && !rsp_item.carry_digit && !rsp_item.negative, "bad digit result not cleared")
   `ASSERT_IMPLY(a_negative_on_sub, clock, reset, rsp_strobe && rsp_item.negative, $past(req_item.action, bcdfp_pkg::PIPE_LATENCY) == bcdfp_pkg::ACTION_SUB && !rsp_item.carry_digit, "negative outside subtraction")

endmodule

bind bcd_fixed_point_add_subtract bcdfp_checker u_bcdfp_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .req_item   (req_item),
   .rsp_strobe (rsp_strobe),
   .rsp_item   (rsp_item)
);

`default_nettype wire

FILE: test/tb_top.sv
// testbench for the packed-bcd fixed-point adder / subtractor
`timescale 1ns / 1ps

import bcdfp_pkg::*;

// predicts every sum or difference and checks the result beats in order
class bcd_scoreboard;
   rsp_type     owed[$];
   int unsigned digits;
   int unsigned mismatches;
   int unsigned checked;
   int unsigned n_add;
   int unsigned n_sub;
   int unsigned n_carry;
   int unsigned n_neg;
   int unsigned n_bad;

   function new(int unsigned digit_count);
      digits     = digit_count;
      mismatches = 0;
      checked    = 0;
      n_add      = 0;
      n_sub      = 0;
      n_carry    = 0;
      n_neg      = 0;
      n_bad      = 0;
   endfunction

   // digitwise decimal add, or larger magnitude minus smaller with the sign apart
   function rsp_type bcd_add_sub(req_type r);
      rsp_type           o;
      logic [DATA_W-1:0] mask;
      logic [DATA_W-1:0] a;
      logic [DATA_W-1:0] b;
      logic [DATA_W-1:0] hi;
      logic [DATA_W-1:0] lo;
      int unsigned       dh;
      int unsigned       dl;
      int unsigned       t;
      logic              carry;
      logic              borrow;
      int                i;
      o    = '0;
      mask = (digits >= NIBBLES) ? '1 : ((64'd1 << (4 * digits)) - 64'd1);
      a    = r.operand_a & mask;
      b    = r.operand_b & mask;
      for (i = 0; i < int'(digits); i++) begin
         if (a[4*i +: 4] > 4'd9 || b[4*i +: 4] > 4'd9) o.bad_digit = 1'b1;
      end
      if (o.bad_digit) return o;
      if (r.action == ACTION_ADD) begin
         carry = 1'b0;
         for (i = 0; i < int'(digits); i++) begin
            t     = a[4*i +: 4] + b[4*i +: 4] + carry;
            carry = (t >= 10);
            if (carry) t = t - 10;
            o.result_bcd[4*i +: 4] = t[3:0];
         end
         o.carry_digit = carry;
      end else begin
         if (a >= b) begin
            hi = a;
            lo = b;
         end else begin
            hi = b;
            lo = a;
            o.negative = 1'b1;
         end
         borrow = 1'b0;
         for (i = 0; i < int'(digits); i++) begin
            dh = hi[4*i +: 4];
            dl = lo[4*i +: 4] + borrow;
            if (dh >= dl) begin
               t      = dh - dl;
               borrow = 1'b0;
            end else begin
               t      = dh + 10 - dl;
               borrow = 1'b1;
            end
            o.result_bcd[4*i +: 4] = t[3:0];
         end
      end
      return o;
   endfunction

   function void note(req_type r);
      rsp_type e;
      e = bcd_add_sub(r);
      owed.push_back(e);
      if (r.action == ACTION_ADD) n_add++;
      else n_sub++;
      if (e.carry_digit) n_carry++;
      if (e.negative) n_neg++;
      if (e.bad_digit) n_bad++;
   endfunction

   function void check(rsp_type got);
      rsp_type e;
      checked++;
      if (owed.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("%0t: result beat with nothing outstanding: %h", $realtime, got);
         return;
      end
      e = owed.pop_front();
      if (got.result_bcd !== e.result_bcd || got.carry_digit !== e.carry_digit ||
          got.negative !== e.negative || got.bad_digit !== e.bad_digit) begin
         mismatches++;
         if (mismatches <= 10) begin
            $display("%0t: mismatch result_bcd exp %h got %h", $realtime,
                     e.result_bcd, got.result_bcd);
            $display("   carry exp %b got %b, negative exp %b got %b, bad exp %b got %b",
                     e.carry_digit, got.carry_digit, e.negative, got.negative,
                     e.bad_digit, got.bad_digit);
         end
      end
   endfunction

   function void close();
      if (owed.size() != 0) begin
         mismatches += owed.size();
         $display("%0d expected results never arrived", owed.size());
      end
   endfunction
endclass

module tb_top;

   // digit count as the block sees it, cut to the 16 nibbles of a field
   localparam int INT_D   = INT_DIGITS_DEFAULT;
   localparam int FRAC_D  = FRAC_DIGITS_DEFAULT;
   localparam int DIGIT_N = (INT_D + FRAC_D > NIBBLES) ? NIBBLES : INT_D + FRAC_D;
   localparam int RANDOM_BEATS = 1300;

   logic    clock = 1'b0;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_item;
   logic    rsp_strobe;
   rsp_type rsp_item;

   bcd_scoreboard book = new(DIGIT_N);

   bcd_fixed_point_add_subtract #(
      .INT_DIGITS (INT_D),
      .FRAC_DIGITS(FRAC_D)
   ) uut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_strobe(rsp_strobe),
      .rsp_item  (rsp_item)
   );

   // 20 ns period
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // sample both channels on the edge itself; inputs change by nonblocking
   // assignment, so these are the values the block saw
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) book.note(req_item);
         if (rsp_strobe) book.check(rsp_item);
      end
   end

   // packed bcd number of len digits, each drawn from lo_d..hi_d
   function automatic logic [DATA_W-1:0] bcd_digits(int unsigned len, int unsigned lo_d,
                                                    int unsigned hi_d);
      logic [DATA_W-1:0] v;
      int                i;
      v = '0;
      for (i = 0; i < int'(len) && i < NIBBLES; i++)
         v[4*i +: 4] = 4'($urandom_range(hi_d, lo_d));
      return v;
   endfunction

   function automatic req_type raw_item();
      req_type r;
      r.action    = 1'($urandom_range(1, 0));
      r.operand_a = {$urandom, $urandom};
      r.operand_b = {$urandom, $urandom};
      return r;
   endfunction

   // mostly well-formed decimal operands, shaped towards long carry and borrow
   // chains, equal and near-equal magnitudes, and some digits out of range
   function automatic req_type random_item();
      req_type     r;
      int unsigned kind;
      int unsigned pos;
      r    = raw_item();
      kind = $urandom_range(99, 0);
      if (kind < 40) begin
         r.operand_a = bcd_digits($urandom_range(NIBBLES, 1), 0, 9);
         r.operand_b = bcd_digits($urandom_range(NIBBLES, 1), 0, 9);
      end else if (kind < 55) begin
         // add: digits that tend to carry; subtract: digits that tend to borrow
         if (r.action == ACTION_ADD) begin
            r.operand_a = bcd_digits(NIBBLES, 4, 9);
            r.operand_b = bcd_digits(NIBBLES, 5, 9);
         end else begin
            r.operand_a = bcd_digits(NIBBLES, 0, 4);
            r.operand_b = bcd_digits(NIBBLES, 5, 9);
            if ($urandom_range(1, 0)) {r.operand_a, r.operand_b} = {r.operand_b, r.operand_a};
         end
      end else if (kind < 65) begin
         r.operand_a = bcd_digits($urandom_range(NIBBLES, 1), 0, 9);
         r.operand_b = r.operand_a;
      end else if (kind < 75) begin
         // one digit apart
         r.operand_a = bcd_digits(NIBBLES, 0, 9);
         r.operand_b = r.operand_a;
         pos         = $urandom_range(NIBBLES - 1, 0);
         r.operand_b[4*pos +: 4] = 4'($urandom_range(9, 0));
      end else if (kind < 85) begin
         r.operand_a = bcd_digits($urandom_range(NIBBLES, 0), 9, 9);
         r.operand_b = $urandom_range(1, 0) ? bcd_digits(NIBBLES, 9, 9)
                                            : bcd_digits($urandom_range(2, 0), 0, 1);
      end else if (kind < 93) begin
         // a single nibble above nine in one operand
         r.operand_a = bcd_digits(NIBBLES, 0, 9);
         r.operand_b = bcd_digits(NIBBLES, 0, 9);
         pos         = $urandom_range(NIBBLES - 1, 0);
         if ($urandom_range(1, 0)) r.operand_a[4*pos +: 4] = 4'($urandom_range(15, 10));
         else r.operand_b[4*pos +: 4] = 4'($urandom_range(15, 10));
      end
      return r;
   endfunction

   function automatic req_type make_item(logic act, logic [DATA_W-1:0] a,
                                         logic [DATA_W-1:0] b);
      req_type r;
      r.action    = act;
      r.operand_a = a;
      r.operand_b = b;
      return r;
   endfunction

   // hold start high until the edge that takes the beat
   task automatic send_beat(input req_type r);
      start    <= 1'b1;
      req_item <= r;
      do @(negedge clock); while (busy);
      @(posedge clock);
   endtask

   // idle stretch of length n: start low, with junk on the payload that must be ignored
   task automatic idle_cycles(input int unsigned n);
      repeat (n) begin
         start    <= 1'b0;
         req_item <= raw_item();
         @(posedge clock);
      end
   endtask

   // most gaps short, a few long, and stretches of back-to-back beats
   int unsigned burst_left = 0;
   task automatic random_gap();
      int unsigned k;
      k = $urandom_range(99, 0);
      if (burst_left > 0) begin
         burst_left--;
      end else if (k < 3) begin
         burst_left = $urandom_range(60, 20);
      end else if (k < 65) begin
         // no gap
      end else if (k < 93) begin
         idle_cycles($urandom_range(3, 1));
      end else begin
         idle_cycles($urandom_range(40, 8));
      end
   endtask

   req_type     directed[$];
   int unsigned drain_guard;

   initial begin
      reset    <= 1'b1;
      start    <= 1'b0;
      req_item <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      idle_cycles(2);

      // extremes, every operation, carry and borrow chains, equal operands,
      // b above a, digits out of range in either operand and all-ones fields
      directed.push_back(make_item(ACTION_ADD, '0, '0));
      directed.push_back(make_item(ACTION_ADD, {16{4'h9}}, {16{4'h9}}));
      directed.push_back(make_item(ACTION_ADD, {16{4'h9}}, 64'h1));
      directed.push_back(make_item(ACTION_ADD, 64'h0999_9999_9999_9999, 64'h1));
      directed.push_back(make_item(ACTION_ADD, {16{4'h5}}, {16{4'h4}}));
      directed.push_back(make_item(ACTION_ADD, {16{4'h8}}, {16{4'h8}}));
      directed.push_back(make_item(ACTION_ADD, 64'h1234_5678_9012_3456, '0));
      directed.push_back(make_item(ACTION_SUB, '0, '0));
      directed.push_back(make_item(ACTION_SUB, 64'h1234_5678_8765_4321,
                                   64'h1234_5678_8765_4321));
      directed.push_back(make_item(ACTION_SUB, {16{4'h9}}, '0));
      directed.push_back(make_item(ACTION_SUB, '0, {16{4'h9}}));
      directed.push_back(make_item(ACTION_SUB, 64'h1000_0000_0000_0000, 64'h1));
      directed.push_back(make_item(ACTION_SUB, 64'h1, 64'h1000_0000_0000_0000));
      directed.push_back(make_item(ACTION_SUB, 64'h50, 64'h49));
      directed.push_back(make_item(ACTION_SUB, 64'h49, 64'h50));
      directed.push_back(make_item(ACTION_ADD, 64'h0000_0000_0000_000A, 64'h1));
      directed.push_back(make_item(ACTION_SUB, 64'h1, 64'hF000_0000_0000_0000));
      directed.push_back(make_item(ACTION_ADD, '1, '1));
      directed.push_back(make_item(ACTION_SUB, '1, '0));
      directed.push_back(make_item(ACTION_SUB, 64'h0000_0000_9999_9999,
                                   64'h0000_0001_0000_0000));
      foreach (directed[i]) begin
         send_beat(directed[i]);
         random_gap();
      end

      repeat (RANDOM_BEATS) begin
         send_beat(random_item());
         random_gap();
      end
      idle_cycles(1);

      // let the pipeline empty, then wait on for stray strobes
      drain_guard = 0;
      while (book.owed.size() != 0 && drain_guard < 1000) begin
         @(posedge clock);
         drain_guard++;
      end
      repeat (PIPE_LATENCY * 3) @(posedge clock);
      book.close();

      $display("checked %0d results: %0d adds, %0d subtracts", book.checked,
               book.n_add, book.n_sub);
      $display("  %0d with carry out, %0d negative, %0d with a digit above nine",
               book.n_carry, book.n_neg, book.n_bad);
      if (book.mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("%0d mismatches", book.mismatches);
         $display("FAILURE");
      end
      $finish;
   end

   // far above the slowest correct run
   initial begin
      #5_000_000;
      $display("timed out");
      $display("FAILURE");
      $finish;
   end

endmodule

FILE: sim.f
+incdir+hdl
hdl/bcdfp_pkg.sv
hdl/bcdfp_stage.sv
hdl/bcd_fixed_point_add_subtract.sv
hdl/bcdfp_checker.sv
test/tb_top.sv
